FILE: src/dta_pkg.sv
// Shared constants and types for the decimal ASCII converter.
// Depends on nothing; the top level and the digit cell import it.
package dta_pkg;

	localparam int VALUE_BITS = 64;
	// Decimal digits needed for the largest VALUE_BITS-bit number.
	localparam int NUM_DIGITS = 20;
	localparam int DIGIT_W = 4;
	localparam int CHAR_W = 6;
	localparam int BIT_CNT_W = $clog2(VALUE_BITS);
	localparam int DIG_CNT_W = $clog2(NUM_DIGITS + 1);

	localparam logic [CHAR_W-1:0] ASCII_ZERO = CHAR_W'(48);
	localparam logic [DIGIT_W-1:0] DIGIT_ADJ_MIN = DIGIT_W'(5);
	localparam logic [DIGIT_W-1:0] DIGIT_ADJ = DIGIT_W'(3);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_CONV = 3'b010,
		ST_EMIT = 3'b100
	} state_t;

	// Control shared by all digit cells.
	typedef struct packed {
		logic clear;
		logic shift_bit;
		logic shift_digit;
	} cell_ctrl_t;

endpackage

FILE: src/u64_to_decimal_ascii.sv
// Unsigned binary to decimal ASCII converter, top level.
// Depends on dta_pkg and dta_bcd_cell.
//
// Each input transaction carries one 64-bit unsigned number. The block answers
// with one output transaction per decimal digit, most significant first, with
// no leading zeros; zero gives the single character '0'. tlast marks the least
// significant digit. A number is loaded, then its bits shift through a chain of
// 20 BCD digit cells, then the digits shift toward the output, where leading
// zeros are dropped and each kept digit waits for m_tready. A new number is
// taken only after the last digit has been delivered.
module u64_to_decimal_ascii (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,  // [63:0] value
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,  // [5:0] digit_char, [7:6] zero
	output logic        m_tlast   // last_digit
);
	import dta_pkg::*;

	state_t                  state_q;
	logic [VALUE_BITS-1:0]   value_q;
	logic [BIT_CNT_W-1:0]    bit_cnt_q;
	logic [DIG_CNT_W-1:0]    remain_q;
	logic                    started_q;
	cell_ctrl_t              ctrl;
	logic                    accept;
	logic                    emit_valid;
	logic                    advance;
	logic                    last_digit;
	logic [NUM_DIGITS-1:0]   carry;
	logic [DIGIT_W-1:0]      digits [NUM_DIGITS];
	logic [DIGIT_W-1:0]      top_digit;

	assign accept = s_tvalid && s_tready;
	assign s_tready = (state_q == ST_IDLE);
	assign top_digit = digits[NUM_DIGITS-1];
	assign last_digit = (remain_q == DIG_CNT_W'(1));

	// Leading zeros are dropped, but the units digit always goes out.
	assign emit_valid = (state_q == ST_EMIT) &&
		(started_q || (top_digit != '0) || last_digit);
	assign advance = (state_q == ST_EMIT) && (!emit_valid || m_tready);

	assign ctrl.clear = accept;
	assign ctrl.shift_bit = (state_q == ST_CONV);
	assign ctrl.shift_digit = advance;

	genvar i;
	generate
		for (i = 0; i < NUM_DIGITS; i++) begin : g_cell
			if (i == 0) begin : g_first
				dta_bcd_cell u_cell (
					.clk       (clk),
					.arst_n    (arst_n),
					.ctrl      (ctrl),
					.bit_in    (value_q[VALUE_BITS-1]),
					.digit_in  ('0),
					.carry_out (carry[i]),
					.digit     (digits[i])
				);
			end else begin : g_next
				dta_bcd_cell u_cell (
					.clk       (clk),
					.arst_n    (arst_n),
					.ctrl      (ctrl),
					.bit_in    (carry[i-1]),
					.digit_in  (digits[i-1]),
					.carry_out (carry[i]),
					.digit     (digits[i])
				);
			end
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			bit_cnt_q <= '0;
			remain_q  <= '0;
			started_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q   <= ST_CONV;
						bit_cnt_q <= '0;
						started_q <= 1'b0;
					end
				end
				ST_CONV: begin
					bit_cnt_q <= bit_cnt_q + BIT_CNT_W'(1);
					if (bit_cnt_q == BIT_CNT_W'(VALUE_BITS - 1)) begin
						state_q  <= ST_EMIT;
						remain_q <= DIG_CNT_W'(NUM_DIGITS);
					end
				end
				ST_EMIT: begin
					if (advance) begin
						remain_q <= remain_q - DIG_CNT_W'(1);
						if (emit_valid) begin
							started_q <= 1'b1;
						end
						if (last_digit) begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			value_q <= s_tdata[VALUE_BITS-1:0];
		end else if (state_q == ST_CONV) begin
			value_q <= {value_q[VALUE_BITS-2:0], 1'b0};
		end
	end

	assign m_tvalid = emit_valid;
	assign m_tdata = {2'b00, ASCII_ZERO + CHAR_W'(top_digit)};
	assign m_tlast = last_digit;

endmodule

FILE: src/dta_bcd_cell.sv
// One BCD digit cell of the shift-and-add-3 chain.
// Depends on dta_pkg.
module dta_bcd_cell (
	input  logic                          clk,
	input  logic                          arst_n,
	input  dta_pkg::cell_ctrl_t           ctrl,
	input  logic                          bit_in,
	input  logic [dta_pkg::DIGIT_W-1:0]   digit_in,
	output logic                          carry_out,
	output logic [dta_pkg::DIGIT_W-1:0]   digit
);
	import dta_pkg::*;

	logic [DIGIT_W-1:0] digit_q;
	logic [DIGIT_W-1:0] adj;

	// A digit of five or more overflows when doubled, so add three first.
	always_comb begin
		adj = (digit_q >= DIGIT_ADJ_MIN) ? digit_q + DIGIT_ADJ : digit_q;
	end

	assign carry_out = adj[DIGIT_W-1];
	assign digit = digit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			digit_q <= '0;
		end else if (ctrl.clear) begin
			digit_q <= '0;
		end else if (ctrl.shift_bit) begin
			digit_q <= {adj[DIGIT_W-2:0], bit_in};
		end else if (ctrl.shift_digit) begin
			digit_q <= digit_in;
		end
	end

endmodule

FILE: src/dta_checker.sv
// Port-level checks for the decimal ASCII converter, bound to the top level.
// Depends on u64_to_decimal_ascii ports only.
module dta_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic [63:0] s_tdata,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [7:0]  m_tdata,
	input logic        m_tlast
);

	// A stalled output transaction holds its digit and its last flag.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("output changed while stalled");

	// A number is never taken while digits of the previous one are pending.
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_tready && m_tvalid))
		else $error("input ready while output valid");

	a_busy_after_load: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("ready did not drop after input transaction");

	a_digit_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[7:4] == 4'b0011) && (m_tdata[3:0] <= 4'd9))
		else $error("output is not a decimal digit");

	a_ready_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && m_tlast |=> s_tready)
		else $error("input not ready after final digit");

endmodule

bind u64_to_decimal_ascii dta_checker u_dta_checker (.*);
